>>> rtl/tcs_pkg.sv
// ----------------------------------------------------------------------------
// tcs_pkg: shared types and constants of the textured column span block
// Register map, opcodes, queue entry and issue structs, texel swizzle.
// ----------------------------------------------------------------------------
package tcs_pkg;

	// Parameter defaults
	localparam int TCS_TEXELS_DEF = 4096;
	localparam int TCS_FRAC_DEF   = 16;

	// Register reset values
	localparam logic [10:0] SCREEN_W_RST = 11'd640;
	localparam logic [10:0] SCREEN_H_RST = 11'd360;
	localparam logic [6:0]  TEX_W_RST    = 7'd64;
	localparam logic [6:0]  TEX_H_RST    = 7'd64;

	// Command queue depth between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Linear texel index width: row (7b) * width (7b) + column
	localparam int LIN_W = 14;

	// Register index, word address paddr[3:2]
	typedef enum logic [1:0] {
		REG_SCREEN_W,
		REG_SCREEN_H,
		REG_TEX_W,
		REG_TEX_H
	} reg_idx_t;

	// Command opcodes
	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_SPAN = 2'd1,
		OP_EMIT = 2'd2
	} op_t;

	// Classified command kind held in the queue
	typedef enum logic [1:0] {
		KIND_LOAD,
		KIND_SPAN,
		KIND_EMIT
	} kind_t;

	typedef struct packed {
		logic [10:0] sw;
		logic [10:0] sh;
		logic [6:0]  tw;
		logic [6:0]  th;
	} cfg_t;

	// Queue entry: a load, a pre-clamped span, or an emit request
	typedef struct packed {
		kind_t        kind;
		logic [11:0]  tindex;
		logic [31:0]  tvalue;
		logic [10:0]  col;
		logic [10:0]  ctop;
		logic [10:0]  cbot;
		logic [6:0]   tcol;
		logic [15:0]  height;
		logic [15:0]  diff;
	} qe_t;

	// Work handed from the sequencer to the pixel pipeline
	typedef struct packed {
		logic         valid;
		logic         load;
		logic         last;
		logic [10:0]  row;
		logic [10:0]  col;
		logic [6:0]   tcol;
		logic [11:0]  tindex;
		logic [31:0]  tvalue;
	} issue_t;

	// RGBA (R in low byte) to ARGB (B in low byte)
	function automatic logic [31:0] pix_swizzle(input logic [31:0] c);
		return {c[31:24], c[7:0], c[15:8], c[23:16]};
	endfunction

endpackage

>>> rtl/tcs_regs.sv
// ----------------------------------------------------------------------------
// tcs_regs: configuration register file
// APB-style write/read of screen and texture dimensions.
// ----------------------------------------------------------------------------
module tcs_regs import tcs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output cfg_t        cfg
);

	cfg_t     cfg_q;
	reg_idx_t ridx;
	logic     wr_en;

	assign ridx  = reg_idx_t'(paddr[3:2]);
	assign wr_en = psel && penable && pwrite;
	assign cfg   = cfg_q;

	// Register writes on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sw <= SCREEN_W_RST;
			cfg_q.sh <= SCREEN_H_RST;
			cfg_q.tw <= TEX_W_RST;
			cfg_q.th <= TEX_H_RST;
		end else if (wr_en) begin
			unique case (ridx)
				REG_SCREEN_W: cfg_q.sw <= pwdata[10:0];
				REG_SCREEN_H: cfg_q.sh <= pwdata[10:0];
				REG_TEX_W:    cfg_q.tw <= pwdata[6:0];
				REG_TEX_H:    cfg_q.th <= pwdata[6:0];
			endcase
		end
	end

	// Read mux
	always_comb begin
		unique case (ridx)
			REG_SCREEN_W: prdata = 32'(cfg_q.sw);
			REG_SCREEN_H: prdata = 32'(cfg_q.sh);
			REG_TEX_W:    prdata = 32'(cfg_q.tw);
			REG_TEX_H:    prdata = 32'(cfg_q.th);
		endcase
	end

endmodule

>>> rtl/tcs_front.sv
// ----------------------------------------------------------------------------
// tcs_front: command front end
// Accepts commands, orders and clamps span ends, drops commands that do
// nothing, and queues the rest for the back end.
// ----------------------------------------------------------------------------
module tcs_front import tcs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         opcode,
	input  logic [11:0]        texel_index,
	input  logic [31:0]        texel_value,
	input  logic signed [15:0] screen_column,
	input  logic signed [15:0] span_top,
	input  logic signed [15:0] span_bottom,
	input  logic signed [15:0] texture_column,
	input  logic               pop,
	output qe_t                head,
	output logic               empty
);

	qe_t                q_mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;

	qe_t                entry;
	logic               keep;
	logic               push;
	logic               on_screen;
	logic signed [15:0] top_o;
	logic signed [15:0] bot_o;
	logic signed [16:0] hdiff;
	logic signed [16:0] neg_top;
	logic [10:0]        last_row;

	// Clamp a signed row into 0..lim
	function automatic logic [10:0] clamp_row(input logic signed [15:0] r,
	                                          input logic [10:0] lim);
		logic [10:0] res;
		if (r[15])
			res = 11'd0;
		else if (r[15:0] > {5'b0, lim})
			res = lim;
		else
			res = r[10:0];
		return res;
	endfunction

	// Classify and pre-compute the queue entry
	always_comb begin
		on_screen = !screen_column[15] && (screen_column[15:0] < {5'b0, cfg.sw});
		if (span_top > span_bottom) begin
			top_o = span_bottom;
			bot_o = span_top;
		end else begin
			top_o = span_top;
			bot_o = span_bottom;
		end
		hdiff    = 17'(bot_o) - 17'(top_o);
		neg_top  = -17'(top_o);
		last_row = (cfg.sh == 11'd0) ? 11'd0 : cfg.sh - 11'd1;

		entry.kind   = KIND_LOAD;
		entry.tindex = texel_index;
		entry.tvalue = texel_value;
		entry.col    = screen_column[10:0];
		entry.ctop   = clamp_row(top_o, last_row);
		entry.cbot   = clamp_row(bot_o, last_row);
		entry.height = hdiff[15:0];
		// only a negative top leaves rows clipped above the screen
		entry.diff   = top_o[15] ? neg_top[15:0] : 16'd0;
		if (texture_column[15] || cfg.tw == 7'd0)
			entry.tcol = 7'd0;
		else if (texture_column[15:0] >= {9'b0, cfg.tw})
			entry.tcol = cfg.tw - 7'd1;
		else
			entry.tcol = texture_column[6:0];

		keep = 1'b0;
		unique case (op_t'(opcode))
			OP_LOAD: begin
				entry.kind = KIND_LOAD;
				keep       = 1'b1;
			end
			OP_SPAN: begin
				entry.kind = KIND_SPAN;
				keep       = on_screen;
			end
			OP_EMIT: begin
				entry.kind = KIND_EMIT;
				keep       = 1'b1;
			end
			default: keep = 1'b0;
		endcase
	end

	assign busy  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign push  = start && !busy && keep;
	assign head  = q_mem_q[rd_ptr_q];

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + QCNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

	// Queue storage
	always_ff @(posedge clk) begin
		if (push)
			q_mem_q[wr_ptr_q] <= entry;
	end

endmodule

>>> rtl/tcs_div.sv
// ----------------------------------------------------------------------------
// tcs_div: restoring divider
// One quotient bit per cycle; done pulses high for a single cycle as the last bit lands in the quotient.
// ----------------------------------------------------------------------------
module tcs_div import tcs_pkg::*; #(
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [15:0]   divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int CW = $clog2(DW + 1);

	logic          run_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [15:0]   rem_q;
	logic [15:0]   dvs_q;
	logic [DW-1:0] quo_q;

	logic [16:0]   rem_sh;
	logic          ge;

	assign rem_sh   = {rem_q, quo_q[DW-1]};
	assign ge       = rem_sh >= {1'b0, dvs_q};
	assign done     = done_q;
	assign quotient = quo_q;

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(DW);
			end else if (run_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: shift in one dividend bit, subtract when it fits
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= ge ? 16'(rem_sh - {1'b0, dvs_q}) : rem_sh[15:0];
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

endmodule

>>> rtl/tcs_seq.sv
// ----------------------------------------------------------------------------
// tcs_seq: back-end sequencer
// Owns the span state, runs span setup through the divider and issues
// texel loads and pixel emits into the pixel pipeline.
// ----------------------------------------------------------------------------
module tcs_seq import tcs_pkg::*; #(
	parameter int FRAC = TCS_FRAC_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  qe_t                  head,
	input  logic                 empty,
	output logic                 pop,
	output logic                 div_start,
	output logic [16+FRAC-1:0]   div_dividend,
	input  logic                 div_done,
	input  logic [16+FRAC-1:0]   div_quo,
	output issue_t               issue_s1,
	output logic [FRAC+8-1:0]    v_s1
);

	localparam int VW = FRAC + 8;
	localparam int DW = 16 + FRAC;

	typedef enum logic [1:0] {
		ST_RUN,
		ST_DIV_STEP,
		ST_DIV_V
	} state_t;

	state_t         state_q;
	logic           active_q;
	logic [10:0]    row_q;
	logic [10:0]    final_q;
	logic [10:0]    col_q;
	logic [6:0]     tcol_q;
	logic [VW-1:0]  v_q;
	logic [FRAC:0]  step_q;

	logic           head_ok;
	logic           is_span;
	logic           row_last;
	logic [VW:0]    v_sum;
	logic [VW-1:0]  v_next;
	logic [VW-1:0]  v0_sat;

	// Pop, divider control and V arithmetic
	always_comb begin
		head_ok  = !empty && (state_q == ST_RUN);
		is_span  = (head.kind == KIND_SPAN);
		pop      = (head_ok && (!is_span || head.height == 16'd0))
		        || (state_q == ST_DIV_V && div_done);
		div_start = (head_ok && is_span && head.height != 16'd0)
		         || (state_q == ST_DIV_STEP && div_done);
		div_dividend = (state_q == ST_RUN) ? DW'(1) << FRAC
		                                   : DW'(head.diff) << FRAC;
		row_last = (row_q == final_q);
		v_sum    = {1'b0, v_q} + (VW+1)'(step_q);
		v_next   = v_sum[VW] ? '1 : v_sum[VW-1:0];
		v0_sat   = (|div_quo[DW-1:VW]) ? '1 : div_quo[VW-1:0];
	end

	// Sequencer state, span registers and issue register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_RUN;
			active_q <= 1'b0;
			row_q    <= '0;
			final_q  <= '0;
			col_q    <= '0;
			tcol_q   <= '0;
			v_q      <= '0;
			step_q   <= '0;
			issue_s1 <= '0;
			v_s1     <= '0;
		end else begin
			issue_s1.valid <= 1'b0;
			unique case (state_q)
				ST_RUN: begin
					if (!empty) begin
						unique case (head.kind)
							KIND_LOAD: begin
								issue_s1.valid  <= 1'b1;
								issue_s1.load   <= 1'b1;
								issue_s1.tindex <= head.tindex;
								issue_s1.tvalue <= head.tvalue;
							end
							KIND_EMIT: begin
								if (active_q) begin
									issue_s1.valid <= 1'b1;
									issue_s1.load  <= 1'b0;
									issue_s1.last  <= row_last;
									issue_s1.row   <= row_q;
									issue_s1.col   <= col_q;
									issue_s1.tcol  <= tcol_q;
									v_s1           <= v_q;
									if (row_last) begin
										active_q <= 1'b0;
									end else begin
										row_q <= row_q + 11'd1;
										v_q   <= v_next;
									end
								end
							end
							KIND_SPAN: begin
								if (head.height == 16'd0) begin
									// flat span: every pixel samples row 0
									active_q <= 1'b1;
									row_q    <= head.ctop;
									final_q  <= head.cbot;
									col_q    <= head.col;
									tcol_q   <= head.tcol;
									v_q      <= '0;
									step_q   <= '0;
								end else begin
									state_q <= ST_DIV_STEP;
								end
							end
							default: state_q <= ST_RUN;
						endcase
					end
				end
				ST_DIV_STEP: begin
					if (div_done) begin
						step_q  <= div_quo[FRAC:0];
						state_q <= ST_DIV_V;
					end
				end
				ST_DIV_V: begin
					if (div_done) begin
						active_q <= 1'b1;
						row_q    <= head.ctop;
						final_q  <= head.cbot;
						col_q    <= head.col;
						tcol_q   <= head.tcol;
						v_q      <= v0_sat;
						state_q  <= ST_RUN;
					end
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end

endmodule

>>> rtl/tcs_pixel.sv
// ----------------------------------------------------------------------------
// tcs_pixel: pixel pipeline and texture store
// Texel row, linear index and modulo reduction, frame buffer address,
// texture store access and ARGB swizzle. Loads ride the same stages so
// store writes and reads keep command order.
// ----------------------------------------------------------------------------
module tcs_pixel import tcs_pkg::*; #(
	parameter int TEXELS = TCS_TEXELS_DEF,
	parameter int FRAC   = TCS_FRAC_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  issue_t            issue_s1,
	input  logic [FRAC+8-1:0] v_s1,
	output logic              result_strobe,
	output logic [19:0]       pixel_address,
	output logic [31:0]       pixel_value,
	output logic              last_pixel
);

	localparam int VW  = FRAC + 8;
	localparam int PVW = VW + 7;
	localparam int TRW = PVW - FRAC;
	localparam int AW  = $clog2(TEXELS);
	localparam int SH  = LIN_W + AW;
	localparam int MW  = LIN_W + 1;
	localparam int PW  = LIN_W + MW;
	localparam longint RECIP_L = (longint'(1) << SH) / TEXELS;
	localparam logic [MW-1:0]    RECIP = MW'(RECIP_L);
	localparam logic [LIN_W-1:0] C_LW  = LIN_W'(TEXELS);

	logic [31:0]      mem_q [TEXELS];

	// Stage valids
	logic             vld_s2, vld_s3, vld_s4, vld_s5;
	logic             load_s2, load_s3, load_s4, load_s5;
	logic             strobe_s6;

	// Stage payload
	logic             last_s2, last_s3, last_s4, last_s5, last_s6;
	logic [PVW-1:0]   vprod_s2;
	logic [21:0]      amul_s2;
	logic [10:0]      col_s2;
	logic [6:0]       tcol_s2;
	logic [11:0]      tindex_s2;
	logic [31:0]      tvalue_s2, tvalue_s3, tvalue_s4, tvalue_s5;
	logic [LIN_W-1:0] lin_s3, lin_s4;
	logic [19:0]      paddr_s3, paddr_s4, paddr_s5, paddr_s6;
	logic [PW-1:0]    prod_s4;
	logic [LIN_W-1:0] r0_s5;
	logic [31:0]      rdata_s6;

	logic [TRW-1:0]   tr_full;
	logic [6:0]       trow;
	logic [LIN_W-1:0] lin;
	logic [LIN_W-1:0] q_est;
	logic [LIN_W-1:0] r_fix;
	logic [AW-1:0]    idx;

	// Texel row clamp and linear index
	always_comb begin
		tr_full = TRW'(vprod_s2 >> FRAC);
		if (cfg.th == 7'd0)
			trow = 7'd0;
		else if (tr_full >= TRW'(cfg.th))
			trow = cfg.th - 7'd1;
		else
			trow = tr_full[6:0];
		if (load_s2)
			lin = LIN_W'(tindex_s2);
		else
			lin = LIN_W'({7'b0, trow} * {7'b0, cfg.tw}) + LIN_W'(tcol_s2);
	end

	// Modulo by the store depth: reciprocal estimate, then one correction
	always_comb begin
		q_est = LIN_W'(prod_s4 >> SH);
		if (32'(r0_s5) >= TEXELS)
			r_fix = r0_s5 - C_LW;
		else
			r_fix = r0_s5;
		idx = AW'(r_fix);
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			strobe_s6 <= 1'b0;
		end else begin
			vld_s2    <= issue_s1.valid;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			vld_s5    <= vld_s4;
			strobe_s6 <= vld_s5 && !load_s5;
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		// s2: scale V by texture height, row times screen width
		load_s2   <= issue_s1.load;
		last_s2   <= issue_s1.last;
		vprod_s2  <= PVW'(v_s1) * PVW'(cfg.th);
		amul_s2   <= 22'(issue_s1.row) * 22'(cfg.sw);
		col_s2    <= issue_s1.col;
		tcol_s2   <= issue_s1.tcol;
		tindex_s2 <= issue_s1.tindex;
		tvalue_s2 <= issue_s1.tvalue;
		// s3: linear texel index, frame buffer address
		load_s3   <= load_s2;
		last_s3   <= last_s2;
		lin_s3    <= lin;
		paddr_s3  <= amul_s2[19:0] + 20'(col_s2);
		tvalue_s3 <= tvalue_s2;
		// s4: reciprocal product
		load_s4   <= load_s3;
		last_s4   <= last_s3;
		lin_s4    <= lin_s3;
		prod_s4   <= PW'(lin_s3) * PW'(RECIP);
		paddr_s4  <= paddr_s3;
		tvalue_s4 <= tvalue_s3;
		// s5: remainder estimate, below twice the depth
		load_s5   <= load_s4;
		last_s5   <= last_s4;
		r0_s5     <= lin_s4 - LIN_W'(q_est * C_LW);
		paddr_s5  <= paddr_s4;
		tvalue_s5 <= tvalue_s4;
		// s6: result fields
		last_s6   <= last_s5;
		paddr_s6  <= paddr_s5;
	end

	// Texture store: write for loads, registered read for emits
	always_ff @(posedge clk) begin
		if (vld_s5 && load_s5)
			mem_q[idx] <= tvalue_s5;
		rdata_s6 <= mem_q[idx];
	end

	assign result_strobe = strobe_s6;
	assign pixel_address = paddr_s6;
	assign pixel_value   = pix_swizzle(rdata_s6);
	assign last_pixel    = last_s6;

endmodule

>>> rtl/textured_column_span.sv
// ----------------------------------------------------------------------------
// textured_column_span: textured wall column renderer
// Front end accepts and classifies commands into a short queue; the back end
// sets up spans and streams pixel writes through a texture pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on start while busy is low: opcode 0 loads a texel, 1 starts
//   a column span, 2 emits the next pixel of the active span. Dimensions are
//   set through the APB port while the block is idle.
//   Each pixel write appears on pixel_address/pixel_value/last_pixel for one
//   cycle with result_strobe high; the receiver takes it in that cycle.
//   An emit's pixel passes the queue, the issue register and stages s2 to s6.
//   Throughput: loads and emits run at one per cycle while the back end is
//   not in span setup. A span start with a nonzero height occupies the back
//   end while the bit-serial divider computes the V step and then start V;
//   commands keep queuing meanwhile and busy rises once the 4-entry queue is
//   full. Commands that do nothing (opcode 3, off-screen span) are dropped.
//   Reset clears the queue, the pipeline and the span state and restores the
//   default dimensions; texture contents are undefined until loaded.
// ----------------------------------------------------------------------------
module textured_column_span import tcs_pkg::*; #(
	parameter int TEXTURE_TEXELS = TCS_TEXELS_DEF,
	parameter int FRACTION_BITS  = TCS_FRAC_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// commands
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         opcode,
	input  logic [11:0]        texel_index,
	input  logic [31:0]        texel_value,
	input  logic signed [15:0] screen_column,
	input  logic signed [15:0] span_top,
	input  logic signed [15:0] span_bottom,
	input  logic signed [15:0] texture_column,
	// results
	output logic               result_strobe,
	output logic [19:0]        pixel_address,
	output logic [31:0]        pixel_value,
	output logic               last_pixel
);

	localparam int DW = 16 + FRACTION_BITS;

	cfg_t                    cfg;
	qe_t                     head;
	logic                    empty;
	logic                    pop;
	logic                    div_start;
	logic                    div_done;
	logic [DW-1:0]           div_dividend;
	logic [DW-1:0]           div_quo;
	issue_t                  issue_s1;
	logic [FRACTION_BITS+7:0] v_s1;

	assign pready = 1'b1;

	tcs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	tcs_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.start          (start),
		.busy           (busy),
		.opcode         (opcode),
		.texel_index    (texel_index),
		.texel_value    (texel_value),
		.screen_column  (screen_column),
		.span_top       (span_top),
		.span_bottom    (span_bottom),
		.texture_column (texture_column),
		.pop            (pop),
		.head           (head),
		.empty          (empty)
	);

	tcs_div #(
		.DW (DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (head.height),
		.done     (div_done),
		.quotient (div_quo)
	);

	tcs_seq #(
		.FRAC (FRACTION_BITS)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.div_start    (div_start),
		.div_dividend (div_dividend),
		.div_done     (div_done),
		.div_quo      (div_quo),
		.issue_s1     (issue_s1),
		.v_s1         (v_s1)
	);

	tcs_pixel #(
		.TEXELS (TEXTURE_TEXELS),
		.FRAC   (FRACTION_BITS)
	) u_pixel (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.issue_s1      (issue_s1),
		.v_s1          (v_s1),
		.result_strobe (result_strobe),
		.pixel_address (pixel_address),
		.pixel_value   (pixel_value),
		.last_pixel    (last_pixel)
	);

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the textured column span renderer
// Drives texel loads, span starts and pixel emits in random bursts, programs
// the four dimension registers over APB between phases, and compares every
// pixel write against an in-bench model of the span walker.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
	import tcs_pkg::*;

	localparam int TEXELS       = TCS_TEXELS_DEF;
	localparam int FRAC         = TCS_FRAC_DEF;
	localparam longint unsigned V_CAP = (64'd1 << (FRAC + 8)) - 1;
	localparam logic [1:0] OP_NONE = 2'd3;
	localparam int SETTLE_CYCLES = 500;
	localparam int TAIL_CYCLES   = 20;
	localparam int RUN_LIMIT     = 600000;

	typedef struct packed {
		logic [1:0]         op;
		logic [11:0]        idx;
		logic [31:0]        val;
		logic signed [15:0] col;
		logic signed [15:0] top;
		logic signed [15:0] bot;
		logic signed [15:0] tcol;
	} cmd_t;

	typedef struct packed {
		logic [19:0] addr;
		logic [31:0] argb;
		logic        last;
	} pixel_t;

	// directed row: command plus an optional hand-computed pixel
	typedef struct packed {
		cmd_t   c;
		logic   typed;
		pixel_t px;
	} dir_step_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [3:0] paddr;
	logic [31:0] pwdata, prdata;
	logic start, busy;
	logic [1:0] opcode;
	logic [11:0] texel_index;
	logic [31:0] texel_value;
	logic signed [15:0] screen_column, span_top, span_bottom, texture_column;
	logic result_strobe;
	logic [19:0] pixel_address;
	logic [31:0] pixel_value;
	logic last_pixel;

	textured_column_span dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy), .opcode(opcode),
		.texel_index(texel_index), .texel_value(texel_value),
		.screen_column(screen_column), .span_top(span_top),
		.span_bottom(span_bottom), .texture_column(texture_column),
		.result_strobe(result_strobe), .pixel_address(pixel_address),
		.pixel_value(pixel_value), .last_pixel(last_pixel)
	);

	always #2 clk = ~clk;

	// span walker model state
	logic [31:0]     texels [TEXELS];
	bit              texel_loaded [TEXELS];
	bit              span_on = 1'b0;
	int unsigned     cur_row = 0, end_row = 0, span_x = 0, span_tcol = 0;
	longint unsigned v_acc = 0, v_inc = 0;
	int unsigned     cfg_sw = SCREEN_W_RST, cfg_sh = SCREEN_H_RST;
	int unsigned     cfg_tw = TEX_W_RST, cfg_th = TEX_H_RST;

	pixel_t pixels_due [$];
	int     cmds_taken = 0;
	int     errors = 0;
	int     cycle_count = 0;
	bit     pin_on = 1'b0;
	pixel_t pin_px;
	int     burst_left = 0;

	// texel store slot the next pixel of the active span reads
	function automatic int texel_slot();
		longint unsigned r;
		r = (v_acc * cfg_th) >> FRAC;
		if (cfg_th == 0)
			r = 0;
		else if (r >= cfg_th)
			r = cfg_th - 1;
		return int'((r * cfg_tw + span_tcol) % TEXELS);
	endfunction

	function automatic void span_setup(input cmd_t c);
		int x, t, b, tc, lastr, ct, cb, h, d, tmp;
		longint unsigned v0;
		x = int'(c.col);
		t = int'(c.top);
		b = int'(c.bot);
		tc = int'(c.tcol);
		lastr = (cfg_sh == 0) ? 0 : int'(cfg_sh) - 1;
		// off-screen column leaves any running span alone
		if (x < 0 || x >= int'(cfg_sw))
			return;
		if (t > b) begin
			tmp = t;
			t = b;
			b = tmp;
		end
		h = b - t;
		ct = (t < 0) ? 0 : (t > lastr) ? lastr : t;
		cb = (b < 0) ? 0 : (b > lastr) ? lastr : b;
		if (tc < 0 || cfg_tw == 0)
			tc = 0;
		else if (tc >= int'(cfg_tw))
			tc = int'(cfg_tw) - 1;
		if (h == 0) begin
			v_inc = 0;
			v_acc = 0;
		end else begin
			d = ct - t;
			v0 = 0;
			v_inc = (64'd1 << FRAC) / longint'(h);
			if (d > 0)
				v0 = (longint'(d) << FRAC) / longint'(h);
			v_acc = (v0 > V_CAP) ? V_CAP : v0;
		end
		span_x = x;
		span_tcol = tc;
		cur_row = ct;
		end_row = cb;
		span_on = 1'b1;
	endfunction

	function automatic void pixel_emit(output bit got, output pixel_t px);
		logic [31:0] c;
		got = 1'b0;
		px = '0;
		if (!span_on)
			return;
		c = texels[texel_slot()];
		got = 1'b1;
		px.addr = 20'((longint'(cur_row) * cfg_sw + span_x) & 20'hFFFFF);
		// RGBA in, ARGB out
		px.argb = {c[31:24], c[7:0], c[15:8], c[23:16]};
		px.last = (cur_row == end_row);
		if (px.last) begin
			span_on = 1'b0;
		end else begin
			cur_row++;
			v_acc += v_inc;
			if (v_acc > V_CAP)
				v_acc = V_CAP;
		end
	endfunction

	// accept transactions into the model, check pixel writes
	always @(posedge clk) begin : pixel_monitor
		cmd_t c;
		pixel_t px, want;
		bit got;
		if (arst_n) begin
			if (start && !busy) begin
				cmds_taken++;
				c = '{opcode, texel_index, texel_value, screen_column, span_top,
					span_bottom, texture_column};
				case (c.op)
					OP_LOAD: begin
						texels[c.idx] = c.val;
						texel_loaded[c.idx] = 1'b1;
					end
					OP_SPAN: span_setup(c);
					OP_EMIT: begin
						pixel_emit(got, px);
						if (pin_on)
							pixels_due.push_back(pin_px);
						else if (got)
							pixels_due.push_back(px);
					end
					default: ;
				endcase
			end
			if (result_strobe) begin
				if (pixels_due.size() == 0) begin
					errors++;
					$display("%0t unexpected pixel: addr %h argb %h last %b", $time,
						pixel_address, pixel_value, last_pixel);
				end else begin
					want = pixels_due.pop_front();
					if (pixel_address !== want.addr || pixel_value !== want.argb ||
						last_pixel !== want.last) begin
						errors++;
						$display("%0t pixel mismatch: expected addr %h argb %h last %b, got addr %h argb %h last %b",
							$time, want.addr, want.argb, want.last,
							pixel_address, pixel_value, last_pixel);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == RUN_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// one transaction, held until the block takes it
	task automatic send_cmd(input cmd_t c, input bit typed, input pixel_t px);
		int target;
		pin_on = typed;
		pin_px = px;
		target = cmds_taken + 1;
		start <= 1'b1;
		opcode <= c.op;
		texel_index <= c.idx;
		texel_value <= c.val;
		screen_column <= c.col;
		span_top <= c.top;
		span_bottom <= c.bot;
		texture_column <= c.tcol;
		do @(negedge clk); while (cmds_taken != target);
		pin_on = 1'b0;
	endtask

	// bursts with random gaps; an emit that would read an empty texel slot
	// gets a load of that slot first
	task automatic paced_send(input cmd_t c, input bit typed, input pixel_t px);
		cmd_t fill;
		int gap, slot;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) :
				$urandom_range(1, 12);
		end
		burst_left--;
		if (c.op == OP_EMIT && span_on) begin
			slot = texel_slot();
			if (!texel_loaded[slot]) begin
				fill = '0;
				fill.op = OP_LOAD;
				fill.idx = 12'(slot);
				fill.val = $urandom;
				send_cmd(fill, 1'b0, '0);
			end
		end
		send_cmd(c, typed, px);
	endtask

	// drain pixels, then give the back end time to finish span setups
	task automatic quiesce(input int extra);
		start <= 1'b0;
		while (pixels_due.size() != 0) @(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	task automatic apb_xfer(input logic wr, input reg_idx_t ri, input logic [31:0] wdata,
		output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {ri, 2'b00};
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
	endtask

	task automatic program_dims(input logic [10:0] w, input logic [10:0] h,
		input logic [6:0] tw, input logic [6:0] th);
		reg_idx_t regs [4];
		logic [31:0] vals [4];
		logic [31:0] rd;
		regs = '{REG_SCREEN_W, REG_SCREEN_H, REG_TEX_W, REG_TEX_H};
		vals = '{32'(w), 32'(h), 32'(tw), 32'(th)};
		foreach (regs[i]) apb_xfer(1'b1, regs[i], vals[i], rd);
		cfg_sw = w;
		cfg_sh = h;
		cfg_tw = tw;
		cfg_th = th;
		// read back what was written
		foreach (regs[i]) begin
			apb_xfer(1'b0, regs[i], '0, rd);
			if (rd !== vals[i]) begin
				errors++;
				$display("%0t register %s readback: expected %h, got %h", $time,
					regs[i].name(), vals[i], rd);
			end
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// mostly span-then-emit runs with random content, plus noise;
	// every accepted transaction, texel fills included, counts toward n
	task automatic random_traffic(input int n);
		cmd_t c;
		int base, kind, lo, hi, tmp, runs;
		base = cmds_taken;
		while (cmds_taken - base < n) begin
			kind = $urandom_range(0, 99);
			c = '0;
			c.val = $urandom;
			c.idx = 12'($urandom);
			if (kind < 70) begin
				c.op = OP_SPAN;
				c.col = 16'($urandom_range(0, cfg_sw - 1));
				lo = int'($urandom_range(0, cfg_sh + 16)) - 8;
				if ($urandom_range(0, 7) == 0)
					hi = int'(16'sh0 + $signed(16'($urandom)));
				else
					hi = lo + int'($urandom_range(0, 24));
				if ($urandom_range(0, 1)) begin
					tmp = lo;
					lo = hi;
					hi = tmp;
				end
				c.top = 16'(lo);
				c.bot = 16'(hi);
				if ($urandom_range(0, 9) == 0)
					c.tcol = 16'($urandom);
				else
					c.tcol = 16'(int'($urandom_range(0, cfg_tw + 3)) - 2);
				paced_send(c, 1'b0, '0);
				runs = $urandom_range(1, 28);
				repeat (runs) begin
					if (cmds_taken - base < n) begin
						c.op = OP_EMIT;
						paced_send(c, 1'b0, '0);
					end
				end
			end else if (kind < 80) begin
				c.op = OP_LOAD;
				paced_send(c, 1'b0, '0);
			end else if (kind < 88) begin
				// mostly off-screen
				c.op = OP_SPAN;
				c.col = 16'($urandom);
				c.top = 16'($urandom);
				c.bot = 16'($urandom);
				c.tcol = 16'($urandom);
				paced_send(c, 1'b0, '0);
			end else if (kind < 94) begin
				c.op = OP_EMIT;
				paced_send(c, 1'b0, '0);
			end else begin
				c.op = OP_NONE;
				c.col = 16'($urandom);
				c.top = 16'($urandom);
				c.bot = 16'($urandom);
				c.tcol = 16'($urandom);
				paced_send(c, 1'b0, '0);
			end
		end
	endtask

	// directed rows at the reset dimensions (640 x 360, 64 x 64 texture)
	dir_step_t dir_steps [25] = '{
		'{'{OP_LOAD, 12'd0,    32'h44332211, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
			1'b0, '{20'd0, 32'd0, 1'b0}},
		'{'{OP_LOAD, 12'd4095, 32'hFFFFFFFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
			1'b0, '{20'd0, 32'd0, 1'b0}},
		'{'{OP_LOAD, 12'd63,   32'h80000001, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
			1'b0, '{20'd0, 32'd0, 1'b0}},
		'{'{OP_LOAD, 12'd4032, 32'h00FF00FF, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
			1'b0, '{20'd0, 32'd0, 1'b0}},
		// emit with no span running
		'{'{OP_EMIT, 12'd0, 32'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
			1'b0, '{20'd0, 32'd0, 1'b0}},
		// zero height span
		'{'{OP_SPAN, 12'd0, 32'd0, 16'sd0, 16'sd5, 16'sd5, 16'sd0},
			1'b0, '{20'd0, 32'd0, 1'b0}},
		'{'{OP_EMIT, 12'd0, 32'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
			1'b1, '{20'd3200, 32'h44112233, 1'b1}},
		'{'{OP_EMIT, 12'd0, 32'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
			1'b0, '{20'd0, 32'd0, 1'b0}},
		// far corner, texture column clamped high
		'{'{OP_SPAN, 12'd0, 32'd0, 16'sd639, 16'sd359, 16'sd359, 16'sd32767},
			1'b0, '{20'd0, 32'd0, 1'b0}},
		'{'{OP_EMIT, 12'd0, 32'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
			1'b1, '{20'd230399, 32'h80010000, 1'b1}},
		// off-screen columns on both sides
		'{'{OP_SPAN, 12'd0, 32'd0, -16'sd1, 16'sd0, 16'sd9, 16'sd0},
			1'b0, '{20'd0, 32'd0, 1'b0}},
		'{'{OP_SPAN, 12'd0, 32'd0, 16'sd640, 16'sd0, 16'sd9, 16'sd0},
			1'b0, '{20'd0, 32'd0, 1'b0}},
		'{'{OP_EMIT, 12'd0, 32'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
			1'b0, '{20'd0, 32'd0, 1'b0}},
		// reversed ends, height one; second row hits the texel row clamp
		'{'{OP_SPAN, 12'd0, 32'd0, 16'sd7, 16'sd1, 16'sd0, -16'sd32768},
			1'b0, '{20'd0, 32'd0, 1'b0}},
		'{'{OP_EMIT, 12'd0, 32'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
			1'b1, '{20'd7, 32'h44112233, 1'b0}},
		'{'{OP_EMIT, 12'd0, 32'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
			1'b1, '{20'd647, 32'h00FF00FF, 1'b1}},
		// full signed range, clipped top
		'{'{OP_SPAN, 12'd0, 32'd0, 16'sd1, -16'sd32768, 16'sd32767, 16'sd1},
			1'b0, '{20'd0, 32'd0, 1'b0}},
		'{'{OP_EMIT, 12'd0, 32'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
			1'b0, '{20'd0, 32'd0, 1'b0}},
		'{'{OP_EMIT, 12'd0, 32'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
			1'b0, '{20'd0, 32'd0, 1'b0}},
		'{'{OP_NONE, 12'hA5A, 32'h5A5A5A5A, 16'sh5A5A, 16'sh5A5A, 16'sh5A5A, 16'sh5A5A},
			1'b0, '{20'd0, 32'd0, 1'b0}},
		// new span replaces the running one; both ends below the screen
		'{'{OP_SPAN, 12'd0, 32'd0, 16'sd3, 16'sd400, 16'sd370, 16'sd63},
			1'b0, '{20'd0, 32'd0, 1'b0}},
		'{'{OP_EMIT, 12'd0, 32'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
			1'b1, '{20'd229763, 32'h80010000, 1'b1}},
		// top clipped so start V reaches the last texel row
		'{'{OP_SPAN, 12'd0, 32'd0, 16'sd2, -16'sd3, 16'sd0, 16'sd0},
			1'b0, '{20'd0, 32'd0, 1'b0}},
		'{'{OP_EMIT, 12'd0, 32'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
			1'b1, '{20'd2, 32'h00FF00FF, 1'b1}},
		'{'{OP_EMIT, 12'd0, 32'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
			1'b0, '{20'd0, 32'd0, 1'b0}}
	};

	initial begin : stimulus
		logic [10:0] w, h;
		logic [6:0] tw, th;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		opcode = OP_LOAD;
		texel_index = '0;
		texel_value = '0;
		screen_column = '0;
		span_top = '0;
		span_bottom = '0;
		texture_column = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_steps[i]) paced_send(dir_steps[i].c, dir_steps[i].typed, dir_steps[i].px);

		// phases: extremes first, then random dimensions
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: begin w = 11'd1024; h = 11'd1024; tw = 7'd64; th = 7'd64; end
				1: begin w = 11'd1;    h = 11'd1;    tw = 7'd1;  th = 7'd1;  end
				2: begin w = 11'd640;  h = 11'd0;    tw = 7'd0;  th = 7'd0;  end
				3: begin w = 11'd1024; h = 11'd1;    tw = 7'd64; th = 7'd1;  end
				4: begin w = 11'd1;    h = 11'd1024; tw = 7'd1;  th = 7'd64; end
				default: begin
					w = 11'($urandom_range(1, 1024));
					h = 11'($urandom_range(1, 1024));
					tw = 7'($urandom_range(1, 64));
					th = 7'($urandom_range(1, 64));
				end
			endcase
			quiesce(SETTLE_CYCLES);
			program_dims(w, h, tw, th);
			random_traffic(72);
		end

		quiesce(TAIL_CYCLES);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
